// ----- hw/rtl/uers_pkg.sv -----
// Types and constants shared by the ultrasonic echo ranging sequencer.
package uers_pkg;

  localparam int unsigned MAX_MODULES = 4;

  // Opcodes of an input beat
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Tick counts within one module's period
  localparam logic [15:0] CLEAR_TICK    = 16'd1;
  localparam logic [15:0] TRIG_OFF_TICK = 16'd2;
  localparam logic [15:0] WINDOW_FIRST  = 16'd43;
  localparam logic [15:0] WINDOW_LAST   = 16'd3800;
  localparam logic [15:0] COUNT_OFFSET  = 16'd41;
  localparam logic [15:0] END_COUNT_RST = 16'd6000;

  // (count - 41) * 10 / 58 == (count - 41) * 5 / 29, done as a multiply by
  // ceil(2^20 / 29) and a shift; exact for every count in the window.
  localparam logic [15:0] CM_RECIP = 16'd36158;
  localparam int unsigned CM_SHIFT = 20;

  typedef struct packed {
    logic       opcode;
    logic [3:0] echo_lines;
    logic [2:0] read_module;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] trigger_lines;
    logic       measuring;
    logic       done_flag;
    logic [2:0] active_module;
    logic [9:0] read_cm;
  } out_beat_t;

endpackage

// ----- hw/rtl/ultrasonic_echo_ranging_sequencer.sv -----
// Top level of the ultrasonic echo ranging sequencer.
//
// Input channel (in_valid / in_stall / in_data): each beat is either a 10 us
// tick or a start command, together with the echo pin levels and the module
// number whose distance is to be reported. The block takes one beat in every
// cycle while in_stall is low; the state is updated at the accepting edge.
// Output channel (out_valid / out_stall / out_data): exactly one result beat
// per input beat, in order, carrying the trigger pin levels, run status, the
// active module and the stored distance of the requested module in cm.
// The result is registered: it is loaded into the output register at the
// accepting edge, or into the skid register while the output is stalled.
// Throughput is one beat per cycle while in_stall is low, set by the single
// state update path (window compare, constant multiply, module select).
// When out_stall is high, one further result parks in a skid register;
// in_stall rises only while that skid register is full.
// cfg_wr_en / cfg_wr_data write the end-of-period tick count; write it only
// while no beats are in flight.
// Reset (rst_n low, synchronous) stops any run, clears the stored
// distances, drops all triggers, empties both output registers and sets the
// end count to 6000.
module ultrasonic_echo_ranging_sequencer #(
  parameter int unsigned NUM_MODULES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uers_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output uers_pkg::out_beat_t out_data,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic [15:0] end_count_r;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [1:0]  current_module_r, current_module_nxt;
  logic        run_active_r, run_active_nxt;
  logic        run_done_r, run_done_nxt;
  logic        trig_acc_r, trig_acc_nxt;
  logic        echo_cap_r, echo_cap_nxt;
  logic [3:0]  trigger_r, trigger_nxt;
  logic [9:0]  cm_r [uers_pkg::MAX_MODULES];
  logic [9:0]  cm_nxt [uers_pkg::MAX_MODULES];

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  uers_pkg::out_beat_t out_data_r, out_data_nxt;
  uers_pkg::out_beat_t skid_data_r, skid_data_nxt;
  uers_pkg::out_beat_t result;

  logic        push, pop;
  logic        echo_bit;
  logic [3:0]  mod_bit;
  logic        last_module;
  logic        in_window;
  logic [11:0] cap_diff;
  logic [14:0] cap_x5;
  logic [30:0] cap_prod;
  logic [9:0]  cap_cm;
  logic        rd_ok;
  logic [1:0]  rd_idx;

  assign push = in_valid && !in_stall;
  assign pop  = out_valid_r && !out_stall;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Distance for a capture at the current count
  assign cap_diff = 12'(tick_count_r - uers_pkg::COUNT_OFFSET);
  assign cap_x5   = 15'(cap_diff) * 15'd5;
  assign cap_prod = 31'(cap_x5) * 31'(uers_pkg::CM_RECIP);
  assign cap_cm   = cap_prod[uers_pkg::CM_SHIFT +: 10];

  assign echo_bit    = in_data.echo_lines[current_module_r];
  assign mod_bit     = 4'(1) << current_module_r;
  assign last_module = (32'(current_module_r) + 32'd1) >= 32'(NUM_MODULES);
  assign in_window   = (tick_count_r >= uers_pkg::WINDOW_FIRST) &&
                       (tick_count_r <= uers_pkg::WINDOW_LAST);

  always_comb begin
    tick_count_nxt     = tick_count_r;
    current_module_nxt = current_module_r;
    run_active_nxt     = run_active_r;
    run_done_nxt       = run_done_r;
    trig_acc_nxt       = trig_acc_r;
    echo_cap_nxt       = echo_cap_r;
    trigger_nxt        = trigger_r;
    cm_nxt             = cm_r;

    if (in_data.opcode == uers_pkg::OP_START) begin
      if (!run_active_r) begin
        run_done_nxt   = 1'b0;
        run_active_nxt = 1'b1;
      end
    end else if (run_active_r) begin
      if (tick_count_r == uers_pkg::CLEAR_TICK) begin
        trigger_nxt                = trigger_r | mod_bit;
        run_done_nxt               = 1'b0;
        cm_nxt[current_module_r]   = '0;
      end else if (tick_count_r == uers_pkg::TRIG_OFF_TICK) begin
        trigger_nxt = trigger_r & ~mod_bit;
      end else if (in_window) begin
        if (!trig_acc_r) begin
          trig_acc_nxt = echo_bit;
        end else if (!echo_cap_r && !echo_bit) begin
          cm_nxt[current_module_r] = cap_cm;
          echo_cap_nxt             = 1'b1;
        end
      end

      // End of this module's period
      if (tick_count_r == end_count_r) begin
        if (last_module) begin
          current_module_nxt = '0;
          run_done_nxt       = 1'b1;
          run_active_nxt     = 1'b0;
        end else begin
          current_module_nxt = current_module_r + 2'd1;
        end
        tick_count_nxt = '0;
        echo_cap_nxt   = 1'b0;
        trig_acc_nxt   = 1'b0;
      end else begin
        tick_count_nxt = tick_count_r + 16'd1;
      end
    end
  end

  assign rd_ok  = (in_data.read_module != 3'd0) &&
                  (32'(in_data.read_module) <= 32'(NUM_MODULES));
  assign rd_idx = 2'(in_data.read_module - 3'd1);

  always_comb begin
    result.trigger_lines = trigger_nxt;
    result.measuring     = run_active_nxt;
    result.done_flag     = run_done_nxt;
    result.active_module = 3'(current_module_nxt) + 3'd1;
    result.read_cm       = rd_ok ? cm_nxt[rd_idx] : 10'd0;
  end

  // Output register with one skid stage behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = result;
        out_valid_nxt = push;
      end
    end else if (push) begin
      // hold the stalled beat, park the new one
      skid_data_nxt  = result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_count_r      <= uers_pkg::END_COUNT_RST;
      tick_count_r     <= '0;
      current_module_r <= '0;
      run_active_r     <= 1'b0;
      run_done_r       <= 1'b0;
      trig_acc_r       <= 1'b0;
      echo_cap_r       <= 1'b0;
      trigger_r        <= '0;
      cm_r             <= '{default: '0};
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        end_count_r <= cfg_wr_data;
      end
      if (push) begin
        tick_count_r     <= tick_count_nxt;
        current_module_r <= current_module_nxt;
        run_active_r     <= run_active_nxt;
        run_done_r       <= run_done_nxt;
        trig_acc_r       <= trig_acc_nxt;
        echo_cap_r       <= echo_cap_nxt;
        trigger_r        <= trigger_nxt;
        cm_r             <= cm_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(run_active_r && run_done_r))
    else $error("run active and done at once");

  assert property (@(posedge clk) disable iff (!rst_n)
    32'(current_module_r) < 32'(NUM_MODULES))
    else $error("current module out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    echo_cap_r |-> trig_acc_r)
    else $error("echo captured before trigger accepted");

  assert property (@(posedge clk) disable iff (!rst_n)
    !run_active_r |-> (tick_count_r == 16'd0))
    else $error("tick count not zero while idle");

endmodule

// ----- sim/tb_ultrasonic_echo_ranging_sequencer.sv -----
// Self-checking testbench for the ultrasonic echo ranging sequencer.
module tb_ultrasonic_echo_ranging_sequencer;

  localparam int NUM_MOD       = 4;
  localparam int US_PER_TICK   = 10;
  localparam int US_PER_CM     = 58;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 160;
  localparam int HOLD_EVERY    = 25000;
  localparam int RANDOM_ITEMS  = 600;
  localparam int NEVER         = 70000;

  typedef struct packed {
    logic               is_cfg;
    logic [15:0]        cfg_val;
    uers_pkg::in_beat_t beat;
  } plan_entry_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  uers_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  uers_pkg::out_beat_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic [15:0]         cfg_wr_data = '0;

  ultrasonic_echo_ranging_sequencer #(.NUM_MODULES(NUM_MOD)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  plan_entry_t         beat_plan[$];
  uers_pkg::out_beat_t pending_results[$];
  int                  n_errors = 0;
  int                  results_seen = 0;
  int                  stim_items = 0;
  int                  plan_end = int'(uers_pkg::END_COUNT_RST);
  logic                beat_taken = 1'b0;

  // Predicted sequencer state
  logic [15:0] rng_end;
  logic [15:0] rng_tick;
  logic [1:0]  rng_mod;
  logic        rng_active;
  logic        rng_done;
  logic        rng_accepted;
  logic        rng_captured;
  logic [15:0] rng_echo_us[NUM_MOD];
  logic [3:0]  rng_trig;

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic void ranging_reset();
    rng_end      = uers_pkg::END_COUNT_RST;
    rng_tick     = '0;
    rng_mod      = '0;
    rng_active   = 1'b0;
    rng_done     = 1'b0;
    rng_accepted = 1'b0;
    rng_captured = 1'b0;
    for (int k = 0; k < NUM_MOD; k++) rng_echo_us[k] = '0;
    rng_trig     = '0;
  endfunction

  function automatic uers_pkg::out_beat_t ranging_step(uers_pkg::in_beat_t b);
    uers_pkg::out_beat_t r;
    logic [1:0]          m;
    logic                echo;
    int                  us;
    int                  cm;
    m    = rng_mod;
    echo = b.echo_lines[m];
    if (b.opcode == uers_pkg::OP_START) begin
      if (!rng_active) begin
        rng_done   = 1'b0;
        rng_active = 1'b1;
      end
    end else if (rng_active) begin
      if (rng_tick == uers_pkg::CLEAR_TICK) begin
        rng_trig[m]    = 1'b1;
        rng_done       = 1'b0;
        rng_echo_us[m] = '0;
      end else if (rng_tick == uers_pkg::TRIG_OFF_TICK) begin
        rng_trig[m] = 1'b0;
      end else if (rng_tick >= uers_pkg::WINDOW_FIRST &&
                   rng_tick <= uers_pkg::WINDOW_LAST) begin
        if (!rng_accepted) begin
          rng_accepted = echo;
        end else if (!rng_captured && !echo) begin
          us             = (int'(rng_tick) - int'(uers_pkg::COUNT_OFFSET)) * US_PER_TICK;
          rng_echo_us[m] = us[15:0];
          rng_captured   = 1'b1;
        end
      end
      // end of this module's period: advance, or finish after the last one
      if (rng_tick == rng_end) begin
        if (int'(m) + 1 >= NUM_MOD) begin
          rng_mod    = '0;
          rng_done   = 1'b1;
          rng_active = 1'b0;
        end else begin
          rng_mod = m + 2'd1;
        end
        rng_tick     = '0;
        rng_captured = 1'b0;
        rng_accepted = 1'b0;
      end else begin
        rng_tick = rng_tick + 16'd1;
      end
    end
    r.trigger_lines = rng_trig;
    r.measuring     = rng_active;
    r.done_flag     = rng_done;
    r.active_module = {1'b0, rng_mod} + 3'd1;
    cm = 0;
    if (b.read_module >= 1 && b.read_module <= NUM_MOD)
      cm = rng_echo_us[b.read_module - 1] / US_PER_CM;
    r.read_cm = cm[9:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic op, logic [3:0] lines, logic [2:0] rd);
    plan_entry_t e;
    e                  = '0;
    e.beat.opcode      = op;
    e.beat.echo_lines  = lines;
    e.beat.read_module = rd;
    beat_plan.push_back(e);
    stim_items++;
  endtask

  task automatic push_cfg(int val);
    plan_entry_t e;
    e         = '0;
    e.is_cfg  = 1'b1;
    e.cfg_val = val[15:0];
    beat_plan.push_back(e);
    plan_end = val;
  endtask

  // n ticks of module m starting at count first_c; echo high on [rise, fall).
  // noise 0: other lines low, 1: other lines random, 2: every line random.
  task automatic add_ticks(int m, int first_c, int n, int rise, int fall, int noise);
    logic [3:0] lines;
    int         c;
    for (int i = 0; i < n; i++) begin
      c = (first_c + i) % 65536;
      // a start in the middle of a run must be ignored
      if ($urandom_range(0, 63) == 0)
        push_beat(uers_pkg::OP_START, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      lines = (noise == 0) ? 4'h0 : 4'($urandom_range(0, 15));
      if (noise != 2) lines[m] = (c >= rise && c < fall);
      push_beat(uers_pkg::OP_TICK, lines, 3'($urandom_range(0, 7)));
    end
  endtask

  task automatic rand_module(int m, int end_c);
    int top;
    int rise;
    int fall;
    int pick;
    int noise;
    top  = (end_c < int'(uers_pkg::WINDOW_LAST)) ? end_c : int'(uers_pkg::WINDOW_LAST);
    pick = $urandom_range(0, 9);
    rise = $urandom_range(0, top + 8);
    fall = rise + $urandom_range(1, 120);
    if (pick == 0) rise = NEVER;
    else if (pick == 1) fall = NEVER;
    noise = (pick == 2) ? 2 : $urandom_range(0, 1);
    add_ticks(m, 0, end_c + 1, rise, fall, noise);
  endtask

  function automatic int pick_end_count();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 3);
    if (sel == 1) return $urandom_range(4, 44);
    if (sel == 2) return $urandom_range(121, 200);
    return $urandom_range(45, 120);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of beats with random gaps; config writes only when quiet
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;
  int quiet_cycles = 0;

  always @(negedge clk) begin
    plan_entry_t        head;
    logic               nxt_valid;
    uers_pkg::in_beat_t nxt_data;
    logic               nxt_cfg_en;
    logic [15:0]        nxt_cfg_data;
    nxt_valid    = in_valid;
    nxt_data     = in_data;
    nxt_cfg_en   = 1'b0;
    nxt_cfg_data = cfg_wr_data;
    if (rst_n && (!in_valid || beat_taken)) begin
      nxt_valid = 1'b0;
      if (beat_plan.size() != 0) begin
        head = beat_plan[0];
        if (head.is_cfg) begin
          // wait for every result to drain, then let the block settle
          if (pending_results.size() != 0 || cfg_wr_en) begin
            quiet_cycles = 0;
          end else if (quiet_cycles < SETTLE_CYCLES) begin
            quiet_cycles++;
          end else begin
            nxt_cfg_en   = 1'b1;
            nxt_cfg_data = head.cfg_val;
            void'(beat_plan.pop_front());
            quiet_cycles = 0;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          nxt_valid = 1'b1;
          nxt_data  = head.beat;
          void'(beat_plan.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid    <= nxt_valid;
    in_data     <= nxt_data;
    cfg_wr_en   <= nxt_cfg_en;
    cfg_wr_data <= nxt_cfg_data;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall in segments of varying density, plus long hold-offs
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int next_hold = 300;
  int seg_left = 0;
  int seg_mode = 0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (results_seen >= next_hold) begin
      // hold off long enough to fill the block and back up the input
      out_stall <= 1'b1;
      hold_left = LONG_HOLD - 1;
      next_hold += HOLD_EVERY;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(20, 200);
      end else begin
        seg_left--;
      end
      case (seg_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict accepted beats, check result beats in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    uers_pkg::out_beat_t want;
    if (!rst_n) begin
      ranging_reset();
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result beat %0d with nothing expected", results_seen));
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want)
            flag_error($sformatf(
              "result %0d: trig=%h meas=%b done=%b mod=%0d cm=%0d, want trig=%h meas=%b done=%b mod=%0d cm=%0d",
              results_seen, out_data.trigger_lines, out_data.measuring, out_data.done_flag,
              out_data.active_module, out_data.read_cm, want.trigger_lines, want.measuring,
              want.done_flag, want.active_module, want.read_cm));
        end
      end
      if (cfg_wr_en) rng_end = cfg_wr_data;
      if (in_valid && !in_stall) pending_results.push_back(ranging_step(in_data));
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int rand_first;

    // idle ticks change nothing before the first start
    for (int r = 0; r < 8; r++)
      push_beat(uers_pkg::OP_TICK, (r % 2) ? 4'hF : 4'h0, 3'(r));

    // reset end count; the second start is ignored
    push_beat(uers_pkg::OP_START, 4'h0, 3'd1);
    push_beat(uers_pkg::OP_START, 4'hF, 3'd7);
    add_ticks(0, 0, 100, 43, 44, 1);        // shortest pulse right at the window opening
    // lower the end count to the running count: the period ends on the next tick
    push_cfg(100);
    add_ticks(0, 100, 1, NEVER, NEVER, 1);
    add_ticks(1, 0, 101, 0, 70, 1);         // echo already high when the window opens
    add_ticks(2, 0, 101, 42, 45, 0);
    add_ticks(3, 0, 101, 50, 100, 2);
    for (int r = 0; r < 8; r++) push_beat(uers_pkg::OP_TICK, 4'hF, 3'(r));

    // end count 0 skips every module, 1 leaves triggers high, 2 drops them
    for (int e = 0; e < 3; e++) begin
      push_cfg(e);
      push_beat(uers_pkg::OP_START, 4'hA, 3'd4);
      for (int m = 0; m < NUM_MOD; m++) add_ticks(m, 0, e + 1, 0, NEVER, 1);
    end

    // random runs with random end counts
    rand_first = stim_items;
    while (stim_items - rand_first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) push_cfg(pick_end_count());
      repeat ($urandom_range(0, 3))
        push_beat(uers_pkg::OP_TICK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      push_beat(uers_pkg::OP_START, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      for (int m = 0; m < NUM_MOD; m++) rand_module(m, plan_end);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beat_plan.size() != 0 || in_valid || pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
